// File: rtl/core/rmfs_pkg.sv
package rmfs_pkg;

  // number formats
  localparam int FRAC_BITS    = 16;
  localparam int CORDIC_STEPS = 20;
  localparam int SQRT_STEPS   = 32;
  localparam int DIV_STEPS    = 32;
  localparam int ANG_FRAC     = 30;
  localparam int ANG_SHIFT    = ANG_FRAC - FRAC_BITS;
  localparam int PRESCALE_SH  = 24;
  localparam int ZW           = 34;
  localparam int ZRW          = ZW + 1;
  localparam int BW           = 19;

  // angle constants in Q30 radians, BEAR_LIM in the Q16 output scale
  localparam longint PI_Q30      = 64'sd3373259426;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint BEAR_LIM    = (PI_Q30 + (64'sd1 <<< (ANG_SHIFT - 1))) >>> ANG_SHIFT;
  localparam logic signed [ZW-1:0]  HALF_PI_Z = ZW'(HALF_PI_Q30);
  localparam logic signed [ZRW-1:0] BEAR_LIM_Z = ZRW'(BEAR_LIM);
  localparam logic signed [ZRW-1:0] ROUND_Z = ZRW'(64'sd1 <<< (ANG_SHIFT - 1));

  // cordic working word
  typedef struct packed {
    logic signed [63:0]   x;
    logic signed [63:0]   y;
    logic signed [ZW-1:0] z;
  } cordic_t;

  typedef struct packed {
    logic [63:0] sumsq;
    logic [63:0] mag;
    logic        neg;
    logic        zero;
  } cord_side_t;

  // root working word
  typedef struct packed {
    logic [63:0] n;
    logic [63:0] r;
  } sqrt_t;

  typedef struct packed {
    logic [63:0]          mag;
    logic                 neg;
    logic signed [BW-1:0] bearing;
  } sqrt_side_t;

  // divider working word
  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] dvd;
    logic [31:0] quo;
  } div_t;

  typedef struct packed {
    logic [31:0]          range;
    logic signed [BW-1:0] bearing;
    logic                 neg;
    logic                 ovf;
  } div_side_t;

  // arctangent of 2^-i in Q30
  function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] i);
    logic signed [ZW-1:0] a;
    unique case (i)
      5'd0:  a = 34'sd843314857;
      5'd1:  a = 34'sd497837829;
      5'd2:  a = 34'sd263043837;
      5'd3:  a = 34'sd133525159;
      5'd4:  a = 34'sd67021687;
      5'd5:  a = 34'sd33543516;
      5'd6:  a = 34'sd16775851;
      5'd7:  a = 34'sd8388437;
      5'd8:  a = 34'sd4194283;
      5'd9:  a = 34'sd2097149;
      5'd10: a = 34'sd1048576;
      5'd11: a = 34'sd524288;
      5'd12: a = 34'sd262144;
      5'd13: a = 34'sd131072;
      5'd14: a = 34'sd65536;
      5'd15: a = 34'sd32768;
      5'd16: a = 34'sd16384;
      5'd17: a = 34'sd8192;
      5'd18: a = 34'sd4096;
      5'd19: a = 34'sd2048;
      5'd20: a = 34'sd1024;
      5'd21: a = 34'sd512;
      5'd22: a = 34'sd256;
      5'd23: a = 34'sd128;
      5'd24: a = 34'sd64;
      5'd25: a = 34'sd32;
      5'd26: a = 34'sd16;
      5'd27: a = 34'sd8;
      5'd28: a = 34'sd4;
      5'd29: a = 34'sd2;
      5'd30: a = 34'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// File: rtl/core/rmfs_if.sv
// track state word
interface rmfs_track_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  modport source(output valid, pos_x, pos_y, vel_x, vel_y, input ready);
  modport sink(input valid, pos_x, pos_y, vel_x, vel_y, output ready);
endinterface

// measurement word
interface rmfs_meas_if;
  logic               valid;
  logic               ready;
  logic [31:0]        range_out;
  logic signed [18:0] bearing_out;
  logic signed [31:0] range_rate_out;
  modport source(output valid, range_out, bearing_out, range_rate_out, input ready);
  modport sink(input valid, range_out, bearing_out, range_rate_out, output ready);
endinterface

// File: rtl/core/rmfs_cordic_cell.sv
module rmfs_cordic_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic [4:0]          step,
  input  logic                up_valid,
  output logic                up_ready,
  input  rmfs_pkg::cordic_t   up_w,
  input  rmfs_pkg::cord_side_t up_s,
  output logic                dn_valid,
  input  logic                dn_ready,
  output rmfs_pkg::cordic_t   dn_w,
  output rmfs_pkg::cord_side_t dn_s
);
  import rmfs_pkg::*;

  logic               v;
  logic signed [63:0] x;
  logic signed [63:0] y;
  logic signed [63:0] xs;
  logic signed [63:0] ys;
  cordic_t            w_next;

  assign up_ready = !v || dn_ready;
  assign dn_valid = v;

  // one micro-rotation, direction from the sign of y
  always_comb begin
    x  = up_w.x;
    y  = up_w.y;
    xs = x >>> step;
    ys = y >>> step;
    if (y > 64'sd0) begin
      w_next.x = x + ys;
      w_next.y = y - xs;
      w_next.z = up_w.z + atan_q30(step);
    end else begin
      w_next.x = x - ys;
      w_next.y = y + xs;
      w_next.z = up_w.z - atan_q30(step);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (up_ready) begin
      v <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_w <= w_next;
      dn_s <= up_s;
    end
  end

endmodule

// File: rtl/core/rmfs_sqrt_cell.sv
module rmfs_sqrt_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [4:0]           step,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  rmfs_pkg::sqrt_t      up_w,
  input  rmfs_pkg::sqrt_side_t up_s,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output rmfs_pkg::sqrt_t      dn_w,
  output rmfs_pkg::sqrt_side_t dn_s
);
  import rmfs_pkg::*;

  logic        v;
  logic [63:0] bitv;
  logic [63:0] trial;
  sqrt_t       w_next;

  assign up_ready = !v || dn_ready;
  assign dn_valid = v;

  // one result bit of the digit-by-digit root
  always_comb begin
    bitv  = 64'd1 << (6'd62 - {step, 1'b0});
    trial = up_w.r + bitv;
    if (up_w.n >= trial) begin
      w_next.n = up_w.n - trial;
      w_next.r = (up_w.r >> 1) + bitv;
    end else begin
      w_next.n = up_w.n;
      w_next.r = up_w.r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (up_ready) begin
      v <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_w <= w_next;
      dn_s <= up_s;
    end
  end

endmodule

// File: rtl/core/rmfs_div_cell.sv
module rmfs_div_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                up_valid,
  output logic                up_ready,
  input  rmfs_pkg::div_t      up_w,
  input  rmfs_pkg::div_side_t up_s,
  output logic                dn_valid,
  input  logic                dn_ready,
  output rmfs_pkg::div_t      dn_w,
  output rmfs_pkg::div_side_t dn_s
);
  import rmfs_pkg::*;

  logic        v;
  logic [32:0] t;
  logic        ge;
  div_t        w_next;

  assign up_ready = !v || dn_ready;
  assign dn_valid = v;

  // one restoring quotient bit
  always_comb begin
    t  = {up_w.rem, up_w.dvd[31]};
    ge = t >= {1'b0, up_s.range};
    w_next.rem = ge ? 32'(t - {1'b0, up_s.range}) : t[31:0];
    w_next.dvd = {up_w.dvd[30:0], 1'b0};
    w_next.quo = {up_w.quo[30:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (up_ready) begin
      v <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_w <= w_next;
      dn_s <= up_s;
    end
  end

endmodule

// File: rtl/core/radar_measurement_from_state_core.sv
// Radar measurement prediction: takes one track word (Q16.16 position and
// velocity) per clock and returns range, bearing and range rate. It is a
// single pipeline of 90 register stages: two for the products and sums, a
// row of 20 CORDIC cells for the bearing, one stage to round and clamp the
// bearing, a row of 32 root cells for the range, two stages to round the
// range and set up the dividend, a row of 32 divider cells for the range
// rate and the output register. Every stage holds its word until the next
// one has room, so a stalled output does not stop the input while any stage
// is empty; with the output ready, one word goes in and one comes out every
// cycle.
module radar_measurement_from_state_core (
  input logic                 clk,
  input logic                 rst,
  rmfs_track_if.sink          track,
  rmfs_meas_if.source         meas
);
  import rmfs_pkg::*;

  // product stage
  logic               a_v, a_take;
  logic [63:0]        a_ax2, a_ay2;
  logic signed [63:0] a_p1, a_p2;
  logic signed [31:0] a_px, a_py;
  logic [31:0]        ax, ay;
  logic signed [63:0] p1_c, p2_c;

  // sum stage and cordic row
  logic               b_take;
  logic [63:0]        m1, m2;
  logic signed [63:0] xe, ye;
  cordic_t            b_w;
  cord_side_t         b_s;
  logic               c_v [CORDIC_STEPS+1];
  logic               c_r [CORDIC_STEPS+1];
  cordic_t            c_w [CORDIC_STEPS+1];
  cord_side_t         c_s [CORDIC_STEPS+1];

  // bearing rounding and root row
  logic               c_take;
  logic signed [ZRW-1:0] zr;
  logic signed [BW-1:0]  bear_c;
  logic               s_v [SQRT_STEPS+1];
  logic               s_r [SQRT_STEPS+1];
  sqrt_t              s_w [SQRT_STEPS+1];
  sqrt_side_t         s_s [SQRT_STEPS+1];

  // range rounding, dividend setup
  logic               d1_v, d1_take, d2_take;
  logic [31:0]        d1_range, r_fin;
  logic [63:0]        d1_mag;
  logic               d1_neg;
  logic signed [BW-1:0] d1_bear;
  logic [63:0]        dividend;
  logic               d_v [DIV_STEPS+1];
  logic               d_r [DIV_STEPS+1];
  div_t               d_w [DIV_STEPS+1];
  div_side_t          d_s [DIV_STEPS+1];

  // output stage
  logic               e_take;
  logic               e_v;
  logic [31:0]        e_range;
  logic signed [BW-1:0] e_bear;
  logic signed [31:0] e_rr;
  logic [31:0]        q;
  logic signed [31:0] rr_c;

  // magnitudes and products
  always_comb begin
    ax   = track.pos_x[31] ? 32'(-track.pos_x) : 32'(track.pos_x);
    ay   = track.pos_y[31] ? 32'(-track.pos_y) : 32'(track.pos_y);
    p1_c = track.pos_x * track.vel_x;
    p2_c = track.pos_y * track.vel_y;
  end

  assign a_take      = !a_v || b_take;
  assign track.ready = a_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (a_take) begin
      a_v <= track.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_take && track.valid) begin
      a_ax2 <= {32'd0, ax} * {32'd0, ax};
      a_ay2 <= {32'd0, ay} * {32'd0, ay};
      a_p1  <= p1_c;
      a_p2  <= p2_c;
      a_px  <= track.pos_x;
      a_py  <= track.pos_y;
    end
  end

  // sum of squares, signed dot product, quadrant turn for the cordic
  always_comb begin
    m1 = a_p1[63] ? 64'(-a_p1) : 64'(a_p1);
    m2 = a_p2[63] ? 64'(-a_p2) : 64'(a_p2);
    b_s.sumsq = a_ax2 + a_ay2;
    b_s.zero  = (a_px == 32'sd0) && (a_py == 32'sd0);
    if (a_p1[63] == a_p2[63]) begin
      b_s.mag = m1 + m2;
      b_s.neg = a_p1[63];
    end else if (m1 >= m2) begin
      b_s.mag = m1 - m2;
      b_s.neg = a_p1[63];
    end else begin
      b_s.mag = m2 - m1;
      b_s.neg = a_p2[63];
    end
    xe = 64'(a_px) <<< PRESCALE_SH;
    ye = 64'(a_py) <<< PRESCALE_SH;
    if (a_px[31] && !a_py[31]) begin
      b_w.x = ye;
      b_w.y = -xe;
      b_w.z = HALF_PI_Z;
    end else if (a_px[31]) begin
      b_w.x = -ye;
      b_w.y = xe;
      b_w.z = -HALF_PI_Z;
    end else begin
      b_w.x = xe;
      b_w.y = ye;
      b_w.z = '0;
    end
  end

  assign b_take = !c_v[0] || c_r[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v[0] <= 1'b0;
    end else if (b_take) begin
      c_v[0] <= a_v;
    end
  end

  always_ff @(posedge clk) begin
    if (b_take && a_v) begin
      c_w[0] <= b_w;
      c_s[0] <= b_s;
    end
  end

  // bearing cells
  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
    rmfs_cordic_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .step     (5'(k)),
      .up_valid (c_v[k]),
      .up_ready (c_r[k]),
      .up_w     (c_w[k]),
      .up_s     (c_s[k]),
      .dn_valid (c_v[k+1]),
      .dn_ready (c_r[k+1]),
      .dn_w     (c_w[k+1]),
      .dn_s     (c_s[k+1])
    );
  end

  // round the angle to the output scale and clamp it to +-pi
  always_comb begin
    zr = (ZRW'(c_w[CORDIC_STEPS].z) + ROUND_Z) >>> ANG_SHIFT;
    if (c_s[CORDIC_STEPS].zero) begin
      bear_c = '0;
    end else if (zr > BEAR_LIM_Z) begin
      bear_c = BW'(BEAR_LIM_Z);
    end else if (zr < -BEAR_LIM_Z) begin
      bear_c = BW'(-BEAR_LIM_Z);
    end else begin
      bear_c = BW'(zr);
    end
  end

  assign c_take = !s_v[0] || s_r[0];
  assign c_r[CORDIC_STEPS] = c_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_v[0] <= 1'b0;
    end else if (c_take) begin
      s_v[0] <= c_v[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (c_take && c_v[CORDIC_STEPS]) begin
      s_w[0].n       <= c_s[CORDIC_STEPS].sumsq;
      s_w[0].r       <= '0;
      s_s[0].mag     <= c_s[CORDIC_STEPS].mag;
      s_s[0].neg     <= c_s[CORDIC_STEPS].neg;
      s_s[0].bearing <= bear_c;
    end
  end

  // range cells
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    rmfs_sqrt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .step     (5'(k)),
      .up_valid (s_v[k]),
      .up_ready (s_r[k]),
      .up_w     (s_w[k]),
      .up_s     (s_s[k]),
      .dn_valid (s_v[k+1]),
      .dn_ready (s_r[k+1]),
      .dn_w     (s_w[k+1]),
      .dn_s     (s_s[k+1])
    );
  end

  // round the root to nearest, floor at one lsb
  assign r_fin   = 32'(s_w[SQRT_STEPS].r + 64'(s_w[SQRT_STEPS].n > s_w[SQRT_STEPS].r));
  assign d1_take = !d1_v || d2_take;
  assign s_r[SQRT_STEPS] = d1_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      d1_v <= 1'b0;
    end else if (d1_take) begin
      d1_v <= s_v[SQRT_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (d1_take && s_v[SQRT_STEPS]) begin
      d1_range <= (r_fin == 32'd0) ? 32'd1 : r_fin;
      d1_mag   <= s_s[SQRT_STEPS].mag;
      d1_neg   <= s_s[SQRT_STEPS].neg;
      d1_bear  <= s_s[SQRT_STEPS].bearing;
    end
  end

  // dividend with half the divisor for rounding, overflow check
  assign dividend = d1_mag + 64'(d1_range >> 1);
  assign d2_take  = !d_v[0] || d_r[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      d_v[0] <= 1'b0;
    end else if (d2_take) begin
      d_v[0] <= d1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (d2_take && d1_v) begin
      d_w[0].rem     <= dividend[63:32];
      d_w[0].dvd     <= dividend[31:0];
      d_w[0].quo     <= '0;
      d_s[0].range   <= d1_range;
      d_s[0].bearing <= d1_bear;
      d_s[0].neg     <= d1_neg;
      d_s[0].ovf     <= dividend[63:32] >= d1_range;
    end
  end

  // range rate divider cells
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    rmfs_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (d_v[k]),
      .up_ready (d_r[k]),
      .up_w     (d_w[k]),
      .up_s     (d_s[k]),
      .dn_valid (d_v[k+1]),
      .dn_ready (d_r[k+1]),
      .dn_w     (d_w[k+1]),
      .dn_s     (d_s[k+1])
    );
  end

  // sign and saturate the quotient
  always_comb begin
    q = d_w[DIV_STEPS].quo;
    if (d_s[DIV_STEPS].neg) begin
      if (d_s[DIV_STEPS].ovf || q[31]) begin
        rr_c = 32'sh8000_0000;
      end else begin
        rr_c = -$signed(q);
      end
    end else begin
      if (d_s[DIV_STEPS].ovf || q[31]) begin
        rr_c = 32'sh7FFF_FFFF;
      end else begin
        rr_c = $signed(q);
      end
    end
  end

  assign e_take = !e_v || meas.ready;
  assign d_r[DIV_STEPS] = e_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_v <= 1'b0;
    end else if (e_take) begin
      e_v <= d_v[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (e_take && d_v[DIV_STEPS]) begin
      e_range <= d_s[DIV_STEPS].range;
      e_bear  <= d_s[DIV_STEPS].bearing;
      e_rr    <= rr_c;
    end
  end

  assign meas.valid          = e_v;
  assign meas.range_out      = e_range;
  assign meas.bearing_out    = e_bear;
  assign meas.range_rate_out = e_rr;

  // checks
  a_range_nonzero: assert property (@(posedge clk) disable iff (rst)
    meas.valid |-> meas.range_out != 32'd0)
    else $error("range word of zero");

  a_bearing_limit: assert property (@(posedge clk) disable iff (rst)
    meas.valid |-> (ZRW'(meas.bearing_out) <= BEAR_LIM_Z) &&
                   (ZRW'(meas.bearing_out) >= -BEAR_LIM_Z))
    else $error("bearing beyond pi");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !meas.valid)
    else $error("output word valid after reset");

  a_no_input_when_full: assert property (@(posedge clk) disable iff (rst)
    (a_v && !b_take) |-> !track.ready)
    else $error("input taken over a held product stage");

endmodule
